@@ hw/rtl/section_address_translator_defines.svh @@
// assertion macros used by the section address translator rtl
`ifndef SECTION_ADDRESS_TRANSLATOR_DEFINES_SVH
`define SECTION_ADDRESS_TRANSLATOR_DEFINES_SVH

`ifndef ASSERT_OFF
`define SAT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("sat assertion failed");
`define SAT_ASSERT_NEXT(lbl, ante, cons) `SAT_ASSERT(lbl, (ante) |=> (cons))
`else
`define SAT_ASSERT(lbl, prop)
`define SAT_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ hw/rtl/sat_pkg.sv @@
// types and constants of the section address translator
`timescale 1ns / 1ps

package sat_pkg;

  localparam int unsigned MaxSectionsDef = 128;

  localparam int unsigned AddrW  = 32;
  localparam int unsigned IndexW = 7;
  localparam int unsigned CountW = 8;

  // command codes carried in tuser
  localparam logic CmdWrite = 1'b0;
  localparam logic CmdQuery = 1'b1;

  // register indexes
  localparam int unsigned RegSectionCount = 0;

  // input tdata layout, lowest bit first
  localparam int unsigned InIdxLsb    = 0;
  localparam int unsigned InStartLsb  = InIdxLsb + IndexW;
  localparam int unsigned InRawLsb    = InStartLsb + AddrW;
  localparam int unsigned InVirtLsb   = InRawLsb + AddrW;
  localparam int unsigned InFptrLsb   = InVirtLsb + AddrW;
  localparam int unsigned InExecLsb   = InFptrLsb + AddrW;
  localparam int unsigned InLookupLsb = InExecLsb + 1;
  localparam int unsigned InUsedW     = InLookupLsb + AddrW;
  localparam int unsigned InDataW     = ((InUsedW + 7) / 8) * 8;

  // output tdata layout, lowest bit first
  localparam int unsigned OutOffsetLsb = 0;
  localparam int unsigned OutOffHitLsb = OutOffsetLsb + AddrW;
  localparam int unsigned OutSecLsb    = OutOffHitLsb + 1;
  localparam int unsigned OutSecHitLsb = OutSecLsb + IndexW;
  localparam int unsigned OutExecLsb   = OutSecHitLsb + 1;
  localparam int unsigned OutUsedW     = OutExecLsb + 1;
  localparam int unsigned OutDataW     = ((OutUsedW + 7) / 8) * 8;

  typedef struct packed {
    logic              cmd;
    logic [IndexW-1:0] entry_index;
    logic [AddrW-1:0]  start_address;
    logic [AddrW-1:0]  raw_size;
    logic [AddrW-1:0]  virtual_size;
    logic [AddrW-1:0]  file_pointer;
    logic              executable;
    logic [AddrW-1:0]  lookup_address;
  } item_t;

  // one table entry as held in the memory
  typedef struct packed {
    logic             exec_mark;
    logic [AddrW-1:0] file_pointer;
    logic [AddrW-1:0] virtual_size;
    logic [AddrW-1:0] raw_size;
    logic [AddrW-1:0] start;
  } entry_t;

  typedef struct packed {
    logic             off_match;
    logic [AddrW-1:0] offset;
    logic             sec_match;
  } match_t;

  typedef struct packed {
    logic [AddrW-1:0]  file_offset;
    logic              offset_hit;
    logic [IndexW-1:0] section_index;
    logic              section_hit;
    logic              index_executable;
  } result_t;

endpackage

@@ hw/rtl/sat_table.sv @@
// section table memory, one write port and one registered read port
`timescale 1ns / 1ps

module sat_table #(
  parameter int unsigned Depth = sat_pkg::MaxSectionsDef,
  parameter int unsigned AddrBits = 7
) (
  input  logic                  clk_i,
  input  logic                  we_i,
  input  logic [AddrBits-1:0]   waddr_i,
  input  sat_pkg::entry_t       wdata_i,
  input  logic [AddrBits-1:0]   raddr_i,
  output sat_pkg::entry_t       rdata_o
);

  sat_pkg::entry_t mem_q [Depth];
  sat_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/sat_match.sv @@
// range checks of one table entry against the lookup address
`timescale 1ns / 1ps

module sat_match (
  input  sat_pkg::entry_t               entry_i,
  input  logic [sat_pkg::AddrW-1:0]     addr_i,
  output sat_pkg::match_t               match_o
);

  logic [sat_pkg::AddrW-1:0] eff_size;
  logic [sat_pkg::AddrW-1:0] sec_size;
  logic [sat_pkg::AddrW-1:0] eff_end;
  logic [sat_pkg::AddrW-1:0] sec_end;
  logic [sat_pkg::AddrW-1:0] delta;
  logic                      above_start;

  always_comb begin
    // file offset rule: virtual size only when nonzero and below raw size
    if ((entry_i.raw_size > entry_i.virtual_size) && (entry_i.virtual_size != '0)) begin
      eff_size = entry_i.virtual_size;
    end else begin
      eff_size = entry_i.raw_size;
    end
    // section rule: virtual size unless unknown
    if (entry_i.virtual_size != '0) begin
      sec_size = entry_i.virtual_size;
    end else begin
      sec_size = entry_i.raw_size;
    end
  end

  // ends wrap modulo 2^32
  assign eff_end     = entry_i.start + eff_size;
  assign sec_end     = entry_i.start + sec_size;
  assign delta       = addr_i - entry_i.start;
  assign above_start = (addr_i >= entry_i.start);

  assign match_o.off_match = above_start && (addr_i < eff_end);
  assign match_o.sec_match = above_start && (addr_i < sec_end);
  assign match_o.offset    = entry_i.file_pointer + delta;

endmodule

@@ hw/rtl/sat_seq.sv @@
// item sequencer: table writes, query walk over the memory and result register
`timescale 1ns / 1ps
`include "section_address_translator_defines.svh"

module sat_seq #(
  parameter int unsigned MaxSections = sat_pkg::MaxSectionsDef,
  parameter int unsigned AddrBits = 7,
  parameter int unsigned CntBits = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [sat_pkg::CountW-1:0]  count_i,
  input  logic                        s_valid_i,
  output logic                        s_ready_o,
  input  sat_pkg::item_t              s_item_i,
  output logic                        m_valid_o,
  input  logic                        m_ready_i,
  output sat_pkg::result_t            m_result_o,
  output logic                        mem_we_o,
  output logic [AddrBits-1:0]         mem_waddr_o,
  output sat_pkg::entry_t             mem_wdata_o,
  output logic [AddrBits-1:0]         mem_raddr_o,
  input  sat_pkg::entry_t             mem_rdata_i
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_EXEC = 4'b0010,
    ST_WALK = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  state_e                        state_q, state_d;
  logic [CntBits-1:0]            rd_cnt_q, rd_cnt_d;
  logic [CntBits-1:0]            used_q, used_d;
  logic                          out_valid_q, out_valid_d;
  sat_pkg::result_t              out_q, out_d;

  logic [sat_pkg::IndexW-1:0]    idx_q, idx_d;
  logic [sat_pkg::AddrW-1:0]     addr_q, addr_d;
  logic [sat_pkg::AddrW-1:0]     offset_q, offset_d;
  logic                          off_hit_q, off_hit_d;
  logic [sat_pkg::IndexW-1:0]    sec_q, sec_d;
  logic                          sec_hit_q, sec_hit_d;
  logic                          exec_q, exec_d;

  logic [CntBits-1:0]            used_cnt;
  logic                          idx_in_table;
  logic [AddrBits-1:0]           idx_addr;
  logic [AddrBits-1:0]           cmp_idx;
  sat_pkg::match_t               match;

  sat_match u_match (
    .entry_i (mem_rdata_i),
    .addr_i  (addr_q),
    .match_o (match)
  );

  // counts above the table depth are clamped
  always_comb begin
    if (32'(count_i) > MaxSections) begin
      used_cnt = CntBits'(MaxSections);
    end else begin
      used_cnt = CntBits'(count_i);
    end
  end

  assign idx_in_table = (32'(s_item_i.entry_index) < MaxSections);
  assign idx_addr     = idx_in_table ? AddrBits'(s_item_i.entry_index) : '0;
  // data on the read port belongs to the entry issued in the previous cycle
  assign cmp_idx      = AddrBits'(rd_cnt_q - CntBits'(1));

  assign mem_waddr_o = idx_addr;
  assign mem_wdata_o = '{exec_mark:    s_item_i.executable,
                         file_pointer: s_item_i.file_pointer,
                         virtual_size: s_item_i.virtual_size,
                         raw_size:     s_item_i.raw_size,
                         start:        s_item_i.start_address};

  always_comb begin
    state_d     = state_q;
    rd_cnt_d    = rd_cnt_q;
    used_d      = used_q;
    out_valid_d = out_valid_q && !m_ready_i;
    out_d       = out_q;
    idx_d       = idx_q;
    addr_d      = addr_q;
    offset_d    = offset_q;
    off_hit_d   = off_hit_q;
    sec_d       = sec_q;
    sec_hit_d   = sec_hit_q;
    exec_d      = exec_q;
    mem_we_o    = 1'b0;
    mem_raddr_o = '0;

    case (state_q)
      ST_IDLE: begin
        if (s_valid_i) begin
          if (s_item_i.cmd == sat_pkg::CmdQuery) begin
            idx_d       = s_item_i.entry_index;
            addr_d      = s_item_i.lookup_address;
            used_d      = used_cnt;
            offset_d    = '0;
            off_hit_d   = 1'b0;
            sec_d       = '0;
            sec_hit_d   = 1'b0;
            mem_raddr_o = idx_addr;
            state_d     = ST_EXEC;
          end else begin
            mem_we_o = idx_in_table;
          end
        end
      end
      ST_EXEC: begin
        exec_d = (CntBits'(idx_q) < used_q) && (32'(idx_q) < MaxSections)
                 && mem_rdata_i.exec_mark;
        if (used_q == '0) begin
          state_d = ST_DONE;
        end else begin
          mem_raddr_o = '0;
          rd_cnt_d    = CntBits'(1);
          state_d     = ST_WALK;
        end
      end
      ST_WALK: begin
        if (!off_hit_q && match.off_match) begin
          offset_d  = match.offset;
          off_hit_d = 1'b1;
        end
        if (!sec_hit_q && match.sec_match) begin
          sec_d     = sat_pkg::IndexW'(cmp_idx);
          sec_hit_d = 1'b1;
        end
        if (rd_cnt_q < used_q) begin
          mem_raddr_o = AddrBits'(rd_cnt_q);
          rd_cnt_d    = rd_cnt_q + CntBits'(1);
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_q || m_ready_i) begin
          out_d = '{file_offset:      offset_q,
                    offset_hit:       off_hit_q,
                    section_index:    sec_q,
                    section_hit:      sec_hit_q,
                    index_executable: exec_q};
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rd_cnt_q    <= '0;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_cnt_q    <= rd_cnt_d;
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q     <= out_d;
    idx_q     <= idx_d;
    addr_q    <= addr_d;
    offset_q  <= offset_d;
    off_hit_q <= off_hit_d;
    sec_q     <= sec_d;
    sec_hit_q <= sec_hit_d;
    exec_q    <= exec_d;
  end

  assign s_ready_o  = (state_q == ST_IDLE);
  assign m_valid_o  = out_valid_q;
  assign m_result_o = out_q;

  `SAT_ASSERT(a_result_from_done, $rose(out_valid_q) |-> $past(state_q == ST_DONE))
  `SAT_ASSERT(a_walk_bound, (state_q == ST_WALK) |-> (rd_cnt_q != '0 && rd_cnt_q <= used_q))
  `SAT_ASSERT(a_hits_clear, (state_q == ST_EXEC) |-> (!off_hit_q && !sec_hit_q))
  `SAT_ASSERT_NEXT(a_off_hit_sticky, (state_q == ST_WALK) && off_hit_q, off_hit_q)
  `SAT_ASSERT(a_write_idle, mem_we_o |-> (state_q == ST_IDLE))

endmodule

@@ hw/rtl/section_address_translator.sv @@
// top level of the section address translator
`timescale 1ns / 1ps

// Section address translator. A table of up to MAX_SECTIONS image sections
// lives in one synchronous memory. A write transaction (tuser = 0) stores one
// entry. A query transaction (tuser = 1) reads the executable mark of
// entry_index, then walks entries 0 to section_count - 1 through the memory
// read port, one entry per cycle, and returns one result. A query holds the
// input until its walk is over and its result is registered, counts above
// MAX_SECTIONS being clamped. A finished result waits in an output register,
// so the next transaction is taken while it is pending; a query that
// finishes while that register is still full holds the input until the
// earlier result is taken. section_count is an apb register at byte
// address 0 and must only be written while no query is in flight. The table
// has no reset; entries below section_count must be written before a query.
module section_address_translator #(
  parameter int unsigned MAX_SECTIONS = sat_pkg::MaxSectionsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // apb configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  // input stream
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // entry_index, start_address, raw_size, virtual_size, file_pointer,
  // executable, lookup_address
  input  logic [sat_pkg::InDataW-1:0]   s_axis_tdata,
  // cmd
  input  logic                          s_axis_tuser,
  // result stream
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // file_offset, offset_hit, section_index, section_hit, index_executable
  output logic [sat_pkg::OutDataW-1:0]  m_axis_tdata
);

  localparam int unsigned AddrBits = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
  localparam int unsigned CntBits  = $clog2(MAX_SECTIONS + 1);

  logic [sat_pkg::CountW-1:0] count_q;
  logic                       reg_sel;
  sat_pkg::item_t             item;
  sat_pkg::result_t           result;
  logic                       mem_we;
  logic [AddrBits-1:0]        mem_waddr;
  logic [AddrBits-1:0]        mem_raddr;
  sat_pkg::entry_t            mem_wdata;
  sat_pkg::entry_t            mem_rdata;

  // register decode on word address
  assign reg_sel = (32'(paddr[2]) == sat_pkg::RegSectionCount);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? 32'(count_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (psel && penable && pwrite && reg_sel) begin
      count_q <= pwdata[sat_pkg::CountW-1:0];
    end
  end

  assign item.cmd            = s_axis_tuser;
  assign item.entry_index    = s_axis_tdata[sat_pkg::InIdxLsb +: sat_pkg::IndexW];
  assign item.start_address  = s_axis_tdata[sat_pkg::InStartLsb +: sat_pkg::AddrW];
  assign item.raw_size       = s_axis_tdata[sat_pkg::InRawLsb +: sat_pkg::AddrW];
  assign item.virtual_size   = s_axis_tdata[sat_pkg::InVirtLsb +: sat_pkg::AddrW];
  assign item.file_pointer   = s_axis_tdata[sat_pkg::InFptrLsb +: sat_pkg::AddrW];
  assign item.executable     = s_axis_tdata[sat_pkg::InExecLsb];
  assign item.lookup_address = s_axis_tdata[sat_pkg::InLookupLsb +: sat_pkg::AddrW];

  sat_table #(
    .Depth    (MAX_SECTIONS),
    .AddrBits (AddrBits)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  sat_seq #(
    .MaxSections (MAX_SECTIONS),
    .AddrBits    (AddrBits),
    .CntBits     (CntBits)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .count_i     (count_q),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_o   (s_axis_tready),
    .s_item_i    (item),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_result_o  (result),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  always_comb begin
    m_axis_tdata = '0;
    m_axis_tdata[sat_pkg::OutOffsetLsb +: sat_pkg::AddrW] = result.file_offset;
    m_axis_tdata[sat_pkg::OutOffHitLsb]                   = result.offset_hit;
    m_axis_tdata[sat_pkg::OutSecLsb +: sat_pkg::IndexW]   = result.section_index;
    m_axis_tdata[sat_pkg::OutSecHitLsb]                   = result.section_hit;
    m_axis_tdata[sat_pkg::OutExecLsb]                     = result.index_executable;
  end

endmodule

@@ sim/tb_section_address_translator.sv @@
// testbench of the section address translator: writes and lookups against a predictor
`timescale 1ns / 1ps

module tb_section_address_translator;
  import sat_pkg::*;

  localparam int unsigned Entries    = MaxSectionsDef;
  localparam int unsigned DrainWait  = Entries + 8;
  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned RandItems  = 900;

  typedef enum logic {RowTransfer, RowCount} row_kind_e;

  typedef struct packed {
    row_kind_e         kind;
    logic [CountW-1:0] count;
    item_t             it;
    logic              typed;
    result_t           want;
  } dir_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [2:0]          paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  // entry_index, start_address, raw_size, virtual_size, file_pointer,
  // executable, lookup_address
  logic [InDataW-1:0]  s_axis_tdata;
  // cmd
  logic                s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  // file_offset, offset_hit, section_index, section_hit, index_executable
  logic [OutDataW-1:0] m_axis_tdata;

  // predictor copy of the section table and the count register
  logic [AddrW-1:0]  sec_start [Entries];
  logic [AddrW-1:0]  sec_raw   [Entries];
  logic [AddrW-1:0]  sec_virt  [Entries];
  logic [AddrW-1:0]  sec_fptr  [Entries];
  logic              sec_exec  [Entries];
  bit                sec_written [Entries];
  logic [CountW-1:0] count_cfg;

  result_t     expected_lookups [$];
  dir_row_t    directed [$];
  int unsigned lookup_errors;
  bit          steady;
  int unsigned cycles;

  section_address_translator dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic result_t translate_lookup(input logic [IndexW-1:0] idx,
                                               input logic [AddrW-1:0]  addr);
    result_t          r;
    int unsigned      n;
    logic [AddrW-1:0] eff;
    logic [AddrW-1:0] sz;
    logic [AddrW-1:0] lim;
    r = '0;
    n = (count_cfg > Entries) ? Entries : count_cfg;
    for (int unsigned i = 0; i < n; i++) begin
      // offset takes the smaller size only when the virtual size is known
      eff = (sec_raw[i] > sec_virt[i] && sec_virt[i] != '0) ? sec_virt[i] : sec_raw[i];
      sz  = (sec_virt[i] != '0) ? sec_virt[i] : sec_raw[i];
      lim = sec_start[i] + eff;
      if (!r.offset_hit && addr >= sec_start[i] && addr < lim) begin
        r.file_offset = sec_fptr[i] + (addr - sec_start[i]);
        r.offset_hit  = 1'b1;
      end
      lim = sec_start[i] + sz;
      if (!r.section_hit && addr >= sec_start[i] && addr < lim) begin
        r.section_index = IndexW'(i);
        r.section_hit   = 1'b1;
      end
    end
    if (idx < n) r.index_executable = sec_exec[idx];
    return r;
  endfunction

  function automatic int unsigned draw_gap();
    if (steady) return 0;
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
  endfunction

  function automatic item_t rand_item(input logic cmd, input logic [IndexW-1:0] idx,
                                      input int unsigned n);
    item_t            it;
    int unsigned      pick;
    logic [AddrW-1:0] base;
    logic [AddrW-1:0] len;
    it.cmd         = cmd;
    it.entry_index = idx;
    case ($urandom_range(0, 3))
      0:       it.start_address = $urandom();
      3:       it.start_address = 32'hFFFF_F000 + $urandom_range(0, 4095);  // may wrap
      default: it.start_address = $urandom_range(0, 32'hFFFF);
    endcase
    case ($urandom_range(0, 4))
      0:       it.raw_size = '0;
      3:       it.raw_size = $urandom();
      4:       it.raw_size = '1;
      default: it.raw_size = $urandom_range(1, 4096);
    endcase
    case ($urandom_range(0, 4))
      0:       it.virtual_size = '0;
      1:       it.virtual_size = it.raw_size;
      2:       it.virtual_size = (it.raw_size > 1) ? $urandom_range(1, it.raw_size - 1) : 32'd1;
      3:       it.virtual_size = it.raw_size + $urandom_range(1, 4096);
      default: it.virtual_size = $urandom();
    endcase
    it.file_pointer   = $urandom();
    it.executable     = 1'($urandom_range(0, 1));
    it.lookup_address = $urandom();
    // aim most lookups at the edges and inside of a live section
    if (cmd == CmdQuery && n != 0 && $urandom_range(0, 4) != 0) begin
      pick = $urandom_range(0, n - 1);
      base = sec_start[pick];
      len  = $urandom_range(0, 1) ? sec_raw[pick] : sec_virt[pick];
      case ($urandom_range(0, 4))
        0:       it.lookup_address = base;
        1:       it.lookup_address = base + len - 1;
        2:       it.lookup_address = base + len;
        3:       it.lookup_address = base - 1;
        default: it.lookup_address = base + ((len != 0) ? $urandom_range(0, len - 1) : 0);
      endcase
    end
    return it;
  endfunction

  function automatic void add_row(input row_kind_e kind, input logic [CountW-1:0] count,
                                  input item_t it, input logic typed, input result_t want);
    dir_row_t row;
    row.kind  = kind;
    row.count = count;
    row.it    = it;
    row.typed = typed;
    row.want  = want;
    directed.push_back(row);
  endfunction

  task automatic send_item(input item_t it, input logic typed, input result_t want);
    int unsigned        gap;
    logic [InDataW-1:0] d;
    gap = draw_gap();
    d   = '0;
    d[InIdxLsb    +: IndexW] = it.entry_index;
    d[InStartLsb  +: AddrW]  = it.start_address;
    d[InRawLsb    +: AddrW]  = it.raw_size;
    d[InVirtLsb   +: AddrW]  = it.virtual_size;
    d[InFptrLsb   +: AddrW]  = it.file_pointer;
    d[InExecLsb]             = it.executable;
    d[InLookupLsb +: AddrW]  = it.lookup_address;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= d;
    s_axis_tuser  <= it.cmd;
    do @(posedge clk_i); while (s_axis_tready !== 1'b1);
    if (it.cmd == CmdWrite) begin
      sec_start[it.entry_index]   = it.start_address;
      sec_raw[it.entry_index]     = it.raw_size;
      sec_virt[it.entry_index]    = it.virtual_size;
      sec_fptr[it.entry_index]    = it.file_pointer;
      sec_exec[it.entry_index]    = it.executable;
      sec_written[it.entry_index] = 1'b1;
    end else begin
      expected_lookups.push_back(typed ? want
                                       : translate_lookup(it.entry_index, it.lookup_address));
    end
  endtask

  task automatic write_section_count(input logic [CountW-1:0] value);
    s_axis_tvalid <= 1'b0;
    while (expected_lookups.size() != 0) @(posedge clk_i);
    // a table write leaves no result, so give a full walk time to finish
    repeat (DrainWait) @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 3'(RegSectionCount * 4);
    pwdata  <= 32'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    count_cfg = value;
  endtask

  initial begin : watchdog
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin : result_sink
    result_t     got;
    result_t     want;
    int unsigned stall;
    m_axis_tready = 1'b0;
    forever begin
      stall = draw_gap();
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (m_axis_tvalid !== 1'b1);
      got.file_offset      = m_axis_tdata[OutOffsetLsb +: AddrW];
      got.offset_hit       = m_axis_tdata[OutOffHitLsb];
      got.section_index    = m_axis_tdata[OutSecLsb +: IndexW];
      got.section_hit      = m_axis_tdata[OutSecHitLsb];
      got.index_executable = m_axis_tdata[OutExecLsb];
      if (expected_lookups.size() == 0) begin
        lookup_errors++;
        if (lookup_errors <= 10)
          $display("unexpected lookup result: offset %h hit %b section %0d hit %b exec %b",
                   got.file_offset, got.offset_hit, got.section_index, got.section_hit,
                   got.index_executable);
      end else begin
        want = expected_lookups.pop_front();
        if (got !== want) begin
          lookup_errors++;
          if (lookup_errors <= 10) begin
            $write("lookup mismatch: expected offset %h hit %b section %0d hit %b exec %b,",
                   want.file_offset, want.offset_hit, want.section_index,
                   want.section_hit, want.index_executable);
            $display(" got offset %h hit %b section %0d hit %b exec %b",
                     got.file_offset, got.offset_hit, got.section_index,
                     got.section_hit, got.index_executable);
          end
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned       rand_done;
    int unsigned       phase;
    int unsigned       lim;
    int unsigned       span;
    logic [CountW-1:0] target;
    logic [IndexW-1:0] idx;
    rst_ni        = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = CmdWrite;
    count_cfg     = '0;
    steady        = 1'b0;
    lookup_errors = 0;

    // empty table after reset: everything misses
    add_row(RowTransfer, '0, {CmdQuery, 7'd0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0},
            1'b1, '0);
    add_row(RowTransfer, '0, {CmdQuery, 7'h7F, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
            32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF}, 1'b1, '0);
    add_row(RowTransfer, '0, {CmdWrite, 7'd0, 32'h1000, 32'h200, 32'h100, 32'h400, 1'b1,
            32'h0}, 1'b0, '0);
    // range wraps past the top of the address space
    add_row(RowTransfer, '0, {CmdWrite, 7'd1, 32'hFFFF_FF00, 32'h200, 32'h0, 32'hFFFF_FFFF,
            1'b0, 32'h0}, 1'b0, '0);
    add_row(RowTransfer, '0, {CmdWrite, 7'd2, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0,
            1'b1, 32'h0}, 1'b0, '0);
    add_row(RowTransfer, '0, {CmdWrite, 7'd3, 32'h1000, 32'h100, 32'h300, 32'h8000_0000,
            1'b0, 32'h0}, 1'b0, '0);
    add_row(RowTransfer, '0, {CmdWrite, 7'h7F, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
            32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF}, 1'b0, '0);
    add_row(RowCount, 8'd4, '0, 1'b0, '0);
    add_row(RowTransfer, '0, {CmdQuery, 7'd0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 32'h1080},
            1'b1, {32'h480, 1'b1, 7'd0, 1'b1, 1'b1});
    add_row(RowTransfer, '0, {CmdQuery, 7'd3, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 32'h1150},
            1'b1, {32'h1150, 1'b1, 7'd2, 1'b1, 1'b0});
    add_row(RowTransfer, '0, {CmdQuery, 7'd4, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0,
            32'hFFFF_FFFF}, 1'b1, '0);
    add_row(RowTransfer, '0, {CmdQuery, 7'd2, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 32'h10FF},
            1'b0, '0);
    add_row(RowTransfer, '0, {CmdQuery, 7'd1, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0,
            32'hFFFF_FF80}, 1'b0, '0);
    add_row(RowTransfer, '0, {CmdQuery, 7'd0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 32'h1100},
            1'b0, '0);
    add_row(RowCount, 8'd1, '0, 1'b0, '0);
    // known virtual size below raw size trims the offset range
    add_row(RowTransfer, '0, {CmdQuery, 7'd0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 32'h11FF},
            1'b1, {32'h0, 1'b0, 7'd0, 1'b0, 1'b1});
    add_row(RowTransfer, '0, {CmdWrite, 7'd0, 32'h2000, 32'h0, 32'h0, 32'h55AA_55AA, 1'b0,
            32'h0}, 1'b0, '0);
    add_row(RowTransfer, '0, {CmdQuery, 7'd0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 32'h2000},
            1'b0, '0);
    add_row(RowTransfer, '0, {CmdQuery, 7'd1, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 32'h1000},
            1'b0, '0);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < directed.size(); r++) begin
      if (directed[r].kind == RowCount) write_section_count(directed[r].count);
      else send_item(directed[r].it, directed[r].typed, directed[r].want);
    end

    rand_done = 0;
    phase     = 0;
    while (rand_done < RandItems) begin
      case (phase)
        0:       target = 8'd1;
        1:       target = CountW'(Entries);
        2:       target = 8'hFF;  // above the table size, clamped by the block
        3:       target = 8'd0;
        default: begin
          case ($urandom_range(0, 9))
            0:       target = 8'd0;
            1:       target = CountW'(Entries);
            2:       target = CountW'($urandom_range(0, Entries));
            default: target = CountW'($urandom_range(1, 10));
          endcase
        end
      endcase
      steady = (phase % 4 == 1);
      lim    = (target > Entries) ? Entries : target;
      // every entry below the new count holds data before any lookup
      for (int unsigned e = 0; e < lim; e++) begin
        if (!sec_written[e]) begin
          send_item(rand_item(CmdWrite, IndexW'(e), 0), 1'b0, '0);
          rand_done++;
        end
      end
      write_section_count(target);
      span = $urandom_range(30, 70);
      for (int unsigned k = 0; k < span; k++) begin
        if (lim != 0 && $urandom_range(0, 1) == 1) idx = IndexW'($urandom_range(0, lim - 1));
        else idx = IndexW'($urandom_range(0, Entries - 1));
        if ($urandom_range(0, 9) < 7) send_item(rand_item(CmdQuery, idx, lim), 1'b0, '0);
        else send_item(rand_item(CmdWrite, idx, lim), 1'b0, '0);
        rand_done++;
      end
      phase++;
    end

    s_axis_tvalid <= 1'b0;
    steady = 1'b0;
    while (expected_lookups.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (lookup_errors == 0 && expected_lookups.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/sat_pkg.sv
hw/rtl/sat_table.sv
hw/rtl/sat_match.sv
hw/rtl/sat_seq.sv
hw/rtl/section_address_translator.sv
sim/tb_section_address_translator.sv
